// File: hw/rtl/positional_list_engine_unit_defines.svh
// Assertion macros shared by the positional list engine RTL.
// Included by the controller and datapath; depends on nothing else.
`ifndef POSITIONAL_LIST_ENGINE_UNIT_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PLE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/ple_pkg.sv
// Package for the positional list engine: field widths, operation and status codes,
// controller states and the command and status bundles between controller and datapath.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ple_pkg;

   localparam int unsigned DEPTH_DEFAULT = 64;

   localparam int unsigned FUNC_W   = 3;
   localparam int unsigned VALUE_W  = 32;
   localparam int unsigned POS_W    = 7;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned CAP_W    = 7;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = 7'd64;

   // Register file: one word at byte address 0.
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] CSR_IDX_CAPACITY = 1'b0;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_APPEND,
      FUNC_PREPEND,
      FUNC_INSERT,
      FUNC_READ,
      FUNC_FIND,
      FUNC_MODIFY,
      FUNC_REMOVE_POS,
      FUNC_REMOVE_VAL
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK,
      STATUS_FULL,
      STATUS_BAD_POS,
      STATUS_NOT_FOUND
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_RD_DATA,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_UP_RD,
      ST_UP_WR,
      ST_UP_FILL,
      ST_DN_RD,
      ST_DN_WR,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      IDX_HOLD,
      IDX_COUNT,
      IDX_ZERO,
      IDX_POS,
      IDX_INC,
      IDX_DEC
   } idx_op_type;

   typedef enum logic [1:0] {
      LOW_COUNT,
      LOW_ZERO,
      LOW_POS
   } low_sel_type;

   typedef enum logic [1:0] {
      RD_POS,
      RD_IDX,
      RD_IDX_M1,
      RD_IDX_P1
   } rd_sel_type;

   typedef enum logic [1:0] {
      WR_LOW_VAL,
      WR_POS_VAL,
      WR_IDX_RDATA
   } wr_sel_type;

   typedef struct packed {
      logic        load;
      logic        status_we;
      status_type  status_val;
      idx_op_type  idx_op;
      logic        low_we;
      low_sel_type low_sel;
      logic        rd_en;
      rd_sel_type  rd_sel;
      logic        wr_en;
      wr_sel_type  wr_sel;
      logic        cnt_inc;
      logic        cnt_dec;
      logic        rval_rd_we;
      logic        rval_val_we;
      logic        fpos_pos_we;
      logic        fpos_idx_we;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      func_type func;
      logic     full;
      logic     pos_ok;
      logic     cnt_zero;
      logic     idx_m1_eq_low;
      logic     idx_last;
      logic     hit;
      logic     out_free;
   } sts_type;

endpackage

`default_nettype wire

// File: hw/rtl/ple_if.sv
// Valid/ready channel interfaces for the request and response items of the list engine.
// Depends on ple_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ple_req_if import ple_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [FUNC_W-1:0]         func;
   logic signed [VALUE_W-1:0] item_value;
   logic [POS_W-1:0]          item_position;

   modport source (output valid, func, item_value, item_position, input ready);
   modport sink   (input valid, func, item_value, item_position, output ready);
endinterface

interface ple_rsp_if import ple_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [STATUS_W-1:0]       status;
   logic signed [VALUE_W-1:0] read_value;
   logic [POS_W-1:0]          found_position;
   logic [POS_W-1:0]          entry_count;
   logic                      is_full;
   logic                      is_empty;

   modport source (output valid, status, read_value, found_position, entry_count, is_full,
                   is_empty, input ready);
   modport sink   (input valid, status, read_value, found_position, entry_count, is_full,
                   is_empty, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/positional_list_engine_unit.sv
// Top level of the positional list engine: register port, controller and datapath.
// Depends on ple_pkg, ple_if, ple_ctrl, ple_datapath and ple_ram.
`timescale 1ns / 1ps
`default_nettype none

// The positional list engine keeps an ordered list of signed 32-bit values addressed by
// 1-based position, up to the smaller of the capacity register and DEPTH entries. It
// handles one request item at a time and returns exactly one response item for each,
// carrying a status, the value and position read or removed, the count afterwards and the
// full and empty flags. The entries live in a single RAM with one write port and one
// registered read port, so every entry that moves or is compared is first read and then
// written or tested. Insert and prepend move up every entry from the given position (the
// first for prepend) to the end; remove at a position moves every later entry down; find
// and remove by value scan from the first entry up to the first match, and remove by
// value then moves every later entry down. The response sits in an output register, so a
// new request is taken while the previous response still waits; the engine stalls only
// when a second response is ready before the first was taken. Entries need no clearing
// after reset, and the capacity register may be written only while the engine is idle.
module positional_list_engine_unit import ple_pkg::*; #(
   parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   ple_req_if.sink               req_chan,
   ple_rsp_if.source             rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   // The capacity register. Only the word index of the address is decoded, and a
   // write lands in the access cycle of the transfer.
   logic [CAP_W-1:0]      capacity_ff, capacity_in;
   logic [CSR_ADDR_W-3:0] csr_index;
   logic                  csr_write;

   assign csr_index = paddr[CSR_ADDR_W-1:2];
   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;

   always_comb begin
      capacity_in = capacity_ff;
      if (csr_write && (csr_index == CSR_IDX_CAPACITY)) begin
         capacity_in = pwdata[CAP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   // Reads of an unmapped word return zero.
   always_comb begin
      if (csr_index == CSR_IDX_CAPACITY) begin
         prdata = CSR_DATA_W'(capacity_ff);
      end else begin
         prdata = '0;
      end
   end

   // The controller sequences each request; the datapath holds the count, the working
   // index, the entry RAM and the response register.
   cmd_type cmd;
   sts_type sts;

   ple_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ple_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .capacity           (capacity_ff),
      .req_func           (req_chan.func),
      .req_item_value     (req_chan.item_value),
      .req_item_position  (req_chan.item_position),
      .rsp_ready          (rsp_chan.ready),
      .rsp_valid          (rsp_chan.valid),
      .rsp_status         (rsp_chan.status),
      .rsp_read_value     (rsp_chan.read_value),
      .rsp_found_position (rsp_chan.found_position),
      .rsp_entry_count    (rsp_chan.entry_count),
      .rsp_is_full        (rsp_chan.is_full),
      .rsp_is_empty       (rsp_chan.is_empty)
   );

endmodule

`default_nettype wire

// File: hw/rtl/ple_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module ple_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/ple_datapath.sv
// Datapath of the list engine: item registers, count and index, entry RAM and result register.
// Depends on ple_pkg, ple_ram and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "positional_list_engine_unit_defines.svh"

module ple_datapath import ple_pkg::*; #(
   parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cmd,
   output sts_type                   sts,
   input  logic [CAP_W-1:0]          capacity,
   input  logic [FUNC_W-1:0]         req_func,
   input  logic signed [VALUE_W-1:0] req_item_value,
   input  logic [POS_W-1:0]          req_item_position,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic signed [VALUE_W-1:0] rsp_read_value,
   output logic [POS_W-1:0]          rsp_found_position,
   output logic [POS_W-1:0]          rsp_entry_count,
   output logic                      rsp_is_full,
   output logic                      rsp_is_empty
);

   localparam int unsigned AW    = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam int unsigned MAX_A = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int unsigned CMP_W = (MAX_A > CAP_W) ? MAX_A : CAP_W;

   // Item registers.
   func_type            func_ff;
   logic [VALUE_W-1:0]  value_ff;
   logic [POS_W-1:0]    pos_ff;

   // Working registers.
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic [CNT_W-1:0]    low_ff, low_in;
   status_type          status_ff, status_in;
   logic [VALUE_W-1:0]  rval_ff, rval_in;
   logic [POS_W-1:0]    fpos_ff, fpos_in;

   // Result register.
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff;
   logic [VALUE_W-1:0]  rsp_rval_ff;
   logic [POS_W-1:0]    rsp_fpos_ff;
   logic [POS_W-1:0]    rsp_count_ff;
   logic                rsp_full_ff;
   logic                rsp_empty_ff;

   logic [CMP_W-1:0]    pos_ext, pos_m1, count_ext, cap_ext, eff_cap, idx_p1_ext;
   logic [CNT_W-1:0]    idx_m1, idx_p1;
   logic                full;

   logic                ram_wr_en;
   logic [AW-1:0]       ram_wr_addr;
   logic [VALUE_W-1:0]  ram_wr_data;
   logic [AW-1:0]       ram_rd_addr;
   logic [VALUE_W-1:0]  ram_rd_data;

   assign pos_ext    = CMP_W'(pos_ff);
   assign pos_m1     = pos_ext - CMP_W'(1);
   assign count_ext  = CMP_W'(count_ff);
   assign cap_ext    = CMP_W'(capacity);
   assign eff_cap    = (cap_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_ext;
   assign full       = count_ext >= eff_cap;
   assign idx_m1     = idx_ff - CNT_W'(1);
   assign idx_p1     = idx_ff + CNT_W'(1);
   assign idx_p1_ext = CMP_W'(idx_p1);

   always_comb begin
      sts.func          = func_ff;
      sts.full          = full;
      sts.pos_ok        = (pos_ext != '0) && (pos_ext <= count_ext);
      sts.cnt_zero      = (count_ff == '0);
      sts.idx_m1_eq_low = (idx_m1 == low_ff);
      sts.idx_last      = (idx_p1 == count_ff);
      sts.hit           = (ram_rd_data == value_ff);
      sts.out_free      = !rsp_valid_ff || rsp_ready;
   end

   // RAM addressing.
   always_comb begin
      case (cmd.rd_sel)
         RD_POS:    ram_rd_addr = pos_m1[AW-1:0];
         RD_IDX:    ram_rd_addr = idx_ff[AW-1:0];
         RD_IDX_M1: ram_rd_addr = idx_m1[AW-1:0];
         RD_IDX_P1: ram_rd_addr = idx_p1[AW-1:0];
         default:   ram_rd_addr = idx_ff[AW-1:0];
      endcase
      ram_wr_en = cmd.wr_en;
      case (cmd.wr_sel)
         WR_LOW_VAL: begin
            ram_wr_addr = low_ff[AW-1:0];
            ram_wr_data = value_ff;
         end
         WR_POS_VAL: begin
            ram_wr_addr = pos_m1[AW-1:0];
            ram_wr_data = value_ff;
         end
         WR_IDX_RDATA: begin
            ram_wr_addr = idx_ff[AW-1:0];
            ram_wr_data = ram_rd_data;
         end
         default: begin
            ram_wr_addr = idx_ff[AW-1:0];
            ram_wr_data = ram_rd_data;
         end
      endcase
   end

   ple_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Next values of the working registers.
   always_comb begin
      case (cmd.idx_op)
         IDX_HOLD:  idx_in = idx_ff;
         IDX_COUNT: idx_in = count_ff;
         IDX_ZERO:  idx_in = '0;
         IDX_POS:   idx_in = pos_m1[CNT_W-1:0];
         IDX_INC:   idx_in = idx_p1;
         IDX_DEC:   idx_in = idx_m1;
         default:   idx_in = idx_ff;
      endcase

      low_in = low_ff;
      if (cmd.low_we) begin
         case (cmd.low_sel)
            LOW_COUNT: low_in = count_ff;
            LOW_ZERO:  low_in = '0;
            LOW_POS:   low_in = pos_m1[CNT_W-1:0];
            default:   low_in = count_ff;
         endcase
      end

      if (cmd.cnt_inc) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CNT_W'(1);
      end else begin
         count_in = count_ff;
      end

      if (cmd.load) begin
         status_in = STATUS_OK;
      end else if (cmd.status_we) begin
         status_in = cmd.status_val;
      end else begin
         status_in = status_ff;
      end

      if (cmd.load) begin
         rval_in = '0;
      end else if (cmd.rval_rd_we) begin
         rval_in = ram_rd_data;
      end else if (cmd.rval_val_we) begin
         rval_in = value_ff;
      end else begin
         rval_in = rval_ff;
      end

      if (cmd.load) begin
         fpos_in = '0;
      end else if (cmd.fpos_pos_we) begin
         fpos_in = pos_ff;
      end else if (cmd.fpos_idx_we) begin
         fpos_in = idx_p1_ext[POS_W-1:0];
      end else begin
         fpos_in = fpos_ff;
      end

      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= func_type'(req_func);
         value_ff <= req_item_value;
         pos_ff   <= req_item_position;
      end
      idx_ff    <= idx_in;
      low_ff    <= low_in;
      status_ff <= status_in;
      rval_ff   <= rval_in;
      fpos_ff   <= fpos_in;
      if (cmd.out_load) begin
         rsp_status_ff <= status_ff;
         rsp_rval_ff   <= rval_ff;
         rsp_fpos_ff   <= fpos_ff;
         rsp_count_ff  <= count_ext[POS_W-1:0];
         rsp_full_ff   <= full;
         rsp_empty_ff  <= (count_ff == '0);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_read_value     = rsp_rval_ff;
   assign rsp_found_position = rsp_fpos_ff;
   assign rsp_entry_count    = rsp_count_ff;
   assign rsp_is_full        = rsp_full_ff;
   assign rsp_is_empty       = rsp_empty_ff;

   `PLE_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ext <= CMP_W'(DEPTH), "count beyond depth")
   `PLE_ASSERT_NOW(a_inc_not_full, clock, reset, cmd.cnt_inc, !full, "insert into a full list")
   `PLE_ASSERT_NEXT(a_count_step, clock, reset, 1'b1, (count_ff == $past(count_ff)) || (count_ff == $past(count_ff) + CNT_W'(1)) || (count_ff == $past(count_ff) - CNT_W'(1)), "count moved by more than one")

endmodule

`default_nettype wire

// File: hw/rtl/ple_ctrl.sv
// Controller state machine of the list engine: sequences decode, scans and entry shifts.
// Depends on ple_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "positional_list_engine_unit_defines.svh"

module ple_ctrl import ple_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end

         ST_DECODE: begin
            case (sts.func)
               FUNC_APPEND, FUNC_PREPEND, FUNC_INSERT: begin
                  if (sts.full) begin
                     cmd.status_we  = 1'b1;
                     cmd.status_val = STATUS_FULL;
                     state_in       = ST_DONE;
                  end else if ((sts.func == FUNC_INSERT) && !sts.pos_ok) begin
                     cmd.status_we  = 1'b1;
                     cmd.status_val = STATUS_BAD_POS;
                     state_in       = ST_DONE;
                  end else begin
                     cmd.idx_op = IDX_COUNT;
                     cmd.low_we = 1'b1;
                     if (sts.func == FUNC_APPEND) begin
                        cmd.low_sel = LOW_COUNT;
                        state_in    = ST_UP_FILL;
                     end else if (sts.func == FUNC_PREPEND) begin
                        cmd.low_sel = LOW_ZERO;
                        state_in    = sts.cnt_zero ? ST_UP_FILL : ST_UP_RD;
                     end else begin
                        cmd.low_sel = LOW_POS;
                        state_in    = ST_UP_RD;
                     end
                  end
               end
               FUNC_READ, FUNC_REMOVE_POS: begin
                  if (!sts.pos_ok) begin
                     cmd.status_we  = 1'b1;
                     cmd.status_val = STATUS_BAD_POS;
                     state_in       = ST_DONE;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_POS;
                     state_in   = ST_RD_DATA;
                  end
               end
               FUNC_MODIFY: begin
                  if (!sts.pos_ok) begin
                     cmd.status_we  = 1'b1;
                     cmd.status_val = STATUS_BAD_POS;
                  end else begin
                     cmd.wr_en  = 1'b1;
                     cmd.wr_sel = WR_POS_VAL;
                  end
                  state_in = ST_DONE;
               end
               FUNC_FIND, FUNC_REMOVE_VAL: begin
                  cmd.status_we  = 1'b1;
                  cmd.status_val = STATUS_NOT_FOUND;
                  cmd.idx_op     = IDX_ZERO;
                  state_in       = sts.cnt_zero ? ST_DONE : ST_SCAN_RD;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end

         ST_RD_DATA: begin
            cmd.rval_rd_we  = 1'b1;
            cmd.fpos_pos_we = 1'b1;
            if (sts.func == FUNC_REMOVE_POS) begin
               cmd.idx_op = IDX_POS;
               state_in   = ST_DN_RD;
            end else begin
               state_in = ST_DONE;
            end
         end

         ST_SCAN_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_IDX;
            state_in   = ST_SCAN_CMP;
         end

         ST_SCAN_CMP: begin
            if (sts.hit) begin
               cmd.status_we   = 1'b1;
               cmd.status_val  = STATUS_OK;
               cmd.fpos_idx_we = 1'b1;
               if (sts.func == FUNC_REMOVE_VAL) begin
                  cmd.rval_val_we = 1'b1;
                  state_in        = ST_DN_RD;
               end else begin
                  state_in = ST_DONE;
               end
            end else if (sts.idx_last) begin
               state_in = ST_DONE;
            end else begin
               cmd.idx_op = IDX_INC;
               state_in   = ST_SCAN_RD;
            end
         end

         ST_UP_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_IDX_M1;
            state_in   = ST_UP_WR;
         end

         ST_UP_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_IDX_RDATA;
            if (sts.idx_m1_eq_low) begin
               state_in = ST_UP_FILL;
            end else begin
               cmd.idx_op = IDX_DEC;
               state_in   = ST_UP_RD;
            end
         end

         ST_UP_FILL: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = WR_LOW_VAL;
            cmd.cnt_inc = 1'b1;
            state_in    = ST_DONE;
         end

         ST_DN_RD: begin
            if (sts.idx_last) begin
               cmd.cnt_dec = 1'b1;
               state_in    = ST_DONE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_IDX_P1;
               state_in   = ST_DN_WR;
            end
         end

         ST_DN_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_IDX_RDATA;
            cmd.idx_op = IDX_INC;
            state_in   = ST_DN_RD;
         end

         ST_DONE: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `PLE_ASSERT_NEXT(a_accept_decodes, clock, reset, req_valid && req_ready, state_ff == ST_DECODE, "accepted item not decoded")
   `PLE_ASSERT_NOW(a_out_slot_free, clock, reset, cmd.out_load, sts.out_free, "result overwrites a pending result")

endmodule

`default_nettype wire

// File: bench/positional_list_engine_unit_test.sv
// Self-checking testbench for the positional list engine: directed and random list operations
// over several capacity settings, each response checked against a behavioral list model.
// Depends on ple_pkg, ple_if and the positional_list_engine_unit RTL.
`timescale 1ns / 1ps

module positional_list_engine_unit_test import ple_pkg::*; ();

   localparam int unsigned LIST_DEPTH    = DEPTH_DEFAULT;
   // The slowest request shifts 63 entries; add the longest stall on either side and a wide
   // margin before calling the engine hung.
   localparam int unsigned STALL_LIMIT   = 3000;
   // Cycles given to the controller to return to idle after its last response is taken.
   localparam int unsigned SETTLE_CYCLES = 16;
   // Quiet time at the end in which a stray response would still show up.
   localparam int unsigned TAIL_CYCLES   = 200;
   localparam int unsigned MAX_REPORTS   = 40;

   typedef struct {
      func_type                  func;
      logic signed [VALUE_W-1:0] value;
      logic [POS_W-1:0]          position;
      bit                        drain;
   } list_request_type;

   typedef struct {
      status_type                status;
      logic signed [VALUE_W-1:0] value;
      logic [POS_W-1:0]          position;
      logic [POS_W-1:0]          count;
      logic                      full;
      logic                      empty;
   } list_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   ple_req_if req_bus ();
   ple_rsp_if rsp_bus ();

   positional_list_engine_unit #(
      .DEPTH (LIST_DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // Shadow of the list held by the engine, updated in the order requests are accepted.
   logic signed [VALUE_W-1:0] stored_vals [LIST_DEPTH];
   int unsigned               stored_len;
   logic [CAP_W-1:0]          capacity_shadow;

   list_request_type pending_requests [$];
   list_result_type  expected_results [$];
   int unsigned   queued_count   = 0;
   int unsigned   accepted_count = 0;
   int unsigned   response_count = 0;
   int unsigned   fail_count     = 0;
   int unsigned   quiet_cycles   = 0;
   int unsigned   req_gap_left   = 0;
   int unsigned   rsp_stall_left = 0;
   bit            req_took       = 1'b0;
   bit            calm_phase     = 1'b0;
   logic signed [VALUE_W-1:0] value_pool [8];

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // The list can hold no more than the register allows, and never more than the RAM depth.
   function automatic int unsigned usable_capacity();
      return (capacity_shadow > LIST_DEPTH) ? LIST_DEPTH : capacity_shadow;
   endfunction

   // Move entries idx..len-1 up one slot to make room at idx.
   function automatic void open_gap(int unsigned idx);
      for (int unsigned i = stored_len; i > idx; i--)
         stored_vals[i] = stored_vals[i - 1];
   endfunction

   // Move every entry above idx down one slot, overwriting idx.
   function automatic void close_gap(int unsigned idx);
      for (int unsigned i = idx; i + 1 < stored_len; i++)
         stored_vals[i] = stored_vals[i + 1];
   endfunction

   // Apply one accepted request to the shadow list and return the response it must produce.
   function automatic list_result_type apply_request(list_request_type rq);
      list_result_type res;
      bit           was_full;
      bit           pos_ok;
      bit           hit;
      int unsigned  slot;
      was_full     = stored_len >= usable_capacity();
      pos_ok       = rq.position >= 1 && rq.position <= stored_len;
      slot         = rq.position - 1;
      hit          = 1'b0;
      res.status   = STATUS_OK;
      res.value    = '0;
      res.position = '0;
      case (rq.func)
         FUNC_APPEND: begin
            if (was_full) begin
               res.status = STATUS_FULL;
            end else begin
               stored_vals[stored_len] = rq.value;
               stored_len++;
            end
         end
         FUNC_PREPEND: begin
            if (was_full) begin
               res.status = STATUS_FULL;
            end else begin
               open_gap(0);
               stored_vals[0] = rq.value;
               stored_len++;
            end
         end
         FUNC_INSERT: begin
            // A full list wins over a bad position.
            if (was_full) begin
               res.status = STATUS_FULL;
            end else if (!pos_ok) begin
               res.status = STATUS_BAD_POS;
            end else begin
               open_gap(slot);
               stored_vals[slot] = rq.value;
               stored_len++;
            end
         end
         FUNC_READ: begin
            if (!pos_ok) begin
               res.status = STATUS_BAD_POS;
            end else begin
               res.value    = stored_vals[slot];
               res.position = rq.position;
            end
         end
         FUNC_FIND, FUNC_REMOVE_VAL: begin
            res.status = STATUS_NOT_FOUND;
            for (int unsigned i = 0; i < stored_len && !hit; i++) begin
               if (stored_vals[i] == rq.value) begin
                  hit  = 1'b1;
                  slot = i;
               end
            end
            if (hit) begin
               res.status   = STATUS_OK;
               res.position = POS_W'(slot + 1);
               if (rq.func == FUNC_REMOVE_VAL) begin
                  res.value = rq.value;
                  close_gap(slot);
                  stored_len--;
               end
            end
         end
         FUNC_MODIFY: begin
            if (!pos_ok)
               res.status = STATUS_BAD_POS;
            else
               stored_vals[slot] = rq.value;
         end
         FUNC_REMOVE_POS: begin
            if (!pos_ok) begin
               res.status = STATUS_BAD_POS;
            end else begin
               res.value    = stored_vals[slot];
               res.position = rq.position;
               close_gap(slot);
               stored_len--;
            end
         end
         default: ;
      endcase
      res.count = POS_W'(stored_len);
      res.full  = stored_len >= usable_capacity();
      res.empty = stored_len == 0;
      return res;
   endfunction

   // Idle length for either side: mostly none, some short, a few long. A calm phase has none.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (calm_phase || roll < 60)
         return 0;
      else if (roll < 92)
         return $urandom_range(1, 3);
      else
         return $urandom_range(10, 40);
   endfunction

   // Values come mostly from a small pool so that find and remove by value hit often.
   function automatic logic signed [VALUE_W-1:0] pick_value();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 45)
         return value_pool[$urandom_range(0, 7)];
      else if (roll < 88)
         return $urandom();
      case ($urandom_range(0, 3))
         0:       return {1'b0, {(VALUE_W - 1){1'b1}}};
         1:       return {1'b1, {(VALUE_W - 1){1'b0}}};
         2:       return '0;
         default: return '1;
      endcase
   endfunction

   // Positions are mostly legal for the estimated length, with the edges and junk mixed in.
   function automatic logic [POS_W-1:0] pick_position(int unsigned est_len);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 70)
         return POS_W'($urandom_range(1, (est_len == 0) ? 1 : est_len));
      else if (roll < 78)
         return '0;
      else if (roll < 86)
         return POS_W'(est_len + 1);
      else if (roll < 93)
         return POS_W'(est_len);
      else
         return POS_W'($urandom_range(0, 127));
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      fail_count++;
      if (fail_count <= MAX_REPORTS)
         $display("mismatch at response %0d: %s got %0h expected %0h", response_count, what,
                  got, want);
   endtask

   task automatic queue_request(func_type f, logic signed [VALUE_W-1:0] v,
                                logic [POS_W-1:0] p, bit drain);
      list_request_type rq;
      rq.func     = f;
      rq.value    = v;
      rq.position = p;
      rq.drain    = drain;
      pending_requests.push_back(rq);
      queued_count++;
   endtask

   // Returns once every queued item was taken and answered and the engine has settled.
   task automatic wait_until_idle();
      while (accepted_count != queued_count || expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Setup cycle, then access cycle held until the write is taken.
   task automatic write_capacity(logic [CAP_W-1:0] cap);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {CSR_IDX_CAPACITY, 2'b00};
      pwdata  <= CSR_DATA_W'(cap);
      @(negedge clock);
      penable <= 1'b1;
      do
         @(posedge clock);
      while (!pready);
      capacity_shadow = cap;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // One phase of random traffic at a given capacity. grow_pct and shrink_pct set the share
   // of inserting and removing requests; the rest read, find or modify.
   task automatic run_random_phase(logic [CAP_W-1:0] cap, int unsigned n_items,
                                   int unsigned grow_pct, int unsigned shrink_pct, bit calm);
      int unsigned est_len;
      int unsigned roll;
      func_type    f;
      wait_until_idle();
      write_capacity(cap);
      calm_phase = calm;
      // The shadow is exact while idle, so the generator starts from the true length.
      est_len = stored_len;
      foreach (value_pool[i])
         value_pool[i] = $urandom();
      for (int unsigned k = 0; k < n_items; k++) begin
         roll = $urandom_range(0, 99);
         if (roll < grow_pct) begin
            case ($urandom_range(0, 2))
               0:       f = FUNC_APPEND;
               1:       f = FUNC_PREPEND;
               default: f = FUNC_INSERT;
            endcase
            if (est_len < usable_capacity())
               est_len++;
         end else if (roll < grow_pct + shrink_pct) begin
            f = $urandom_range(0, 1) ? FUNC_REMOVE_POS : FUNC_REMOVE_VAL;
            if (est_len > 0)
               est_len--;
         end else begin
            case ($urandom_range(0, 2))
               0:       f = FUNC_READ;
               1:       f = FUNC_FIND;
               default: f = FUNC_MODIFY;
            endcase
         end
         // Halfway through, and now and then at random, the sender holds the next item
         // until every outstanding response has come back.
         queue_request(f, pick_value(), pick_position(est_len),
                       k == n_items / 2 || $urandom_range(0, 199) == 0);
      end
   endtask

   // Request driver: a new item goes out at the falling edge once the previous one was taken
   // and its gap has run out. An item flagged for draining waits for an empty scoreboard.
   always @(negedge clock) begin
      list_request_type rq;
      bit            send;
      send = 1'b0;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!(req_bus.valid && !req_took)) begin
         if (req_gap_left > 0) begin
            req_gap_left--;
         end else if (pending_requests.size() != 0 &&
                      (!pending_requests[0].drain || expected_results.size() == 0)) begin
            rq                    = pending_requests.pop_front();
            send                  = 1'b1;
            req_gap_left          = pick_gap();
            req_bus.func          <= rq.func;
            req_bus.item_value    <= rq.value;
            req_bus.item_position <= rq.position;
         end
         req_bus.valid <= send;
      end
   end

   // Response sink: ready drops for random stretches, whether or not a response is waiting.
   always @(negedge clock) begin
      if (rsp_stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall_left--;
      end else begin
         rsp_bus.ready <= 1'b1;
         rsp_stall_left = pick_gap();
      end
   end

   // Monitor: checks each taken response against the oldest expectation, then predicts the
   // response of a request taken at the same edge.
   always @(posedge clock) begin
      list_request_type rq;
      list_result_type  want;
      req_took = 1'b0;
      if (!reset) begin
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            response_count++;
            if (expected_results.size() == 0) begin
               report_mismatch("response with nothing outstanding", 1, 0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_bus.status !== want.status)
                  report_mismatch("status", rsp_bus.status, want.status);
               if (rsp_bus.read_value !== want.value)
                  report_mismatch("read_value", rsp_bus.read_value, want.value);
               if (rsp_bus.found_position !== want.position)
                  report_mismatch("found_position", rsp_bus.found_position, want.position);
               if (rsp_bus.entry_count !== want.count)
                  report_mismatch("entry_count", rsp_bus.entry_count, want.count);
               if (rsp_bus.is_full !== want.full)
                  report_mismatch("is_full", rsp_bus.is_full, want.full);
               if (rsp_bus.is_empty !== want.empty)
                  report_mismatch("is_empty", rsp_bus.is_empty, want.empty);
            end
         end
         req_took = req_bus.valid && req_bus.ready === 1'b1;
         if (req_took) begin
            rq.func     = func_type'(req_bus.func);
            rq.value    = req_bus.item_value;
            rq.position = req_bus.item_position;
            rq.drain    = 1'b0;
            expected_results.push_back(apply_request(rq));
            accepted_count++;
         end
      end
   end

   // Watchdog: too long without any item moving on either channel means the engine hung.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("positional_list_engine_unit_test failed");
         $finish;
      end
   end

   initial begin
      req_bus.valid         = 1'b0;
      req_bus.func          = '0;
      req_bus.item_value    = '0;
      req_bus.item_position = '0;
      rsp_bus.ready         = 1'b0;
      psel                  = 1'b0;
      penable               = 1'b0;
      pwrite                = 1'b0;
      paddr                 = '0;
      pwdata                = '0;
      capacity_shadow       = CAPACITY_RESET;
      stored_len            = 0;
      foreach (stored_vals[i])
         stored_vals[i] = '0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset capacity. Everything on an empty list is rejected first,
      // including an insert, which can only ever be a bad position there.
      queue_request(FUNC_READ,       32'sd0, 7'd1, 1'b0);
      queue_request(FUNC_INSERT,     32'sd7, 7'd1, 1'b0);
      queue_request(FUNC_REMOVE_POS, 32'sd0, 7'd1, 1'b0);
      queue_request(FUNC_FIND,       32'sd0, 7'd0, 1'b0);
      queue_request(FUNC_REMOVE_VAL, 32'sd0, 7'd0, 1'b0);
      queue_request(FUNC_MODIFY,     32'sd3, 7'd1, 1'b0);
      // Build max, min, then -1 in front, 0 inside and a value just below the end.
      queue_request(FUNC_APPEND,  32'sh7FFF_FFFF, 7'd0, 1'b0);
      queue_request(FUNC_APPEND,  32'sh8000_0000, 7'd0, 1'b0);
      queue_request(FUNC_PREPEND, -32'sd1,        7'd0, 1'b0);
      queue_request(FUNC_INSERT,  32'sd0,         7'd2, 1'b0);
      queue_request(FUNC_INSERT,  32'sd12345,     7'd4, 1'b0);
      // Positions zero, one past the end, the last one and one with the top bit set.
      queue_request(FUNC_READ, 32'sd0, 7'd0,   1'b0);
      queue_request(FUNC_READ, 32'sd0, 7'd6,   1'b0);
      queue_request(FUNC_READ, 32'sd0, 7'd5,   1'b0);
      queue_request(FUNC_READ, 32'sd0, 7'd127, 1'b0);
      // Modify must reach the last entry.
      queue_request(FUNC_MODIFY, 32'sh5555_5555, 7'd5, 1'b0);
      queue_request(FUNC_FIND,   32'sh5555_5555, 7'd0, 1'b0);
      queue_request(FUNC_FIND,   32'sd0,         7'd0, 1'b0);
      // Remove by value really removes, and a miss leaves the count alone.
      queue_request(FUNC_REMOVE_VAL, 32'sh7FFF_FFFF, 7'd0, 1'b0);
      queue_request(FUNC_REMOVE_VAL, 32'sh7FFF_FFFF, 7'd0, 1'b0);
      queue_request(FUNC_REMOVE_POS, 32'sd0,         7'd1, 1'b0);
      queue_request(FUNC_REMOVE_POS, 32'sd0,         7'd3, 1'b0);
      queue_request(FUNC_INSERT,     32'sd9,         7'd64, 1'b0);
      queue_request(FUNC_APPEND,     32'sh2AAA_AAAA, 7'd0, 1'b0);
      queue_request(FUNC_APPEND,     32'sh1234_5678, 7'd0, 1'b0);

      // The list now holds four entries, so the first setting lowers the capacity below the
      // count. Zero capacity follows, then the smallest legal one, then a value above the
      // depth that must saturate, then the depth itself. Most of the traffic runs at small
      // capacities, where requests finish quickly.
      run_random_phase(7'd2,   40,  40, 30, 1'b0);
      run_random_phase(7'd0,   60,  30, 45, 1'b0);
      run_random_phase(7'd1,   100, 40, 35, 1'b0);
      run_random_phase(7'd127, 200, 70, 15, 1'b0);
      run_random_phase(7'd64,  120, 40, 40, 1'b1);
      run_random_phase(7'd5,   250, 45, 35, 1'b0);
      run_random_phase(7'd12,  250, 45, 35, 1'b0);
      run_random_phase(7'd3,   200, 45, 35, 1'b1);
      run_random_phase(7'd8,   180, 45, 35, 1'b0);
      run_random_phase(7'd20,  150, 50, 35, 1'b0);

      wait_until_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_results.size() != 0)
         report_mismatch("responses never delivered", expected_results.size(), 0);
      if (fail_count == 0)
         $display("positional_list_engine_unit_test passed");
      else
         $display("positional_list_engine_unit_test failed");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/ple_pkg.sv
hw/rtl/ple_if.sv
hw/rtl/ple_ram.sv
hw/rtl/ple_datapath.sv
hw/rtl/ple_ctrl.sv
hw/rtl/positional_list_engine_unit.sv
bench/positional_list_engine_unit_test.sv
